### src/caqf_pkg.sv
// Shared types and constants for the CIGAR alignment quality filter.
package caqf_pkg;

  localparam int COUNT_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH        = 4;
  localparam int LEN_W              = 28;
  localparam int PCT_W              = 7;
  localparam int PERCENT_SCALE      = 100;
  localparam int KIND_COUNT         = 5;

  typedef enum logic [3:0] {
    OP_MATCH  = 4'd0,
    OP_INSERT = 4'd1,
    OP_DELETE = 4'd2,
    OP_SOFT   = 4'd4,
    OP_HARD   = 4'd5
  } op_code_t;

  typedef enum logic [2:0] {
    KIND_M = 3'd0,
    KIND_I = 3'd1,
    KIND_D = 3'd2,
    KIND_S = 3'd3,
    KIND_H = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    REG_ID_ON      = 3'd0,
    REG_ID_PCT     = 3'd1,
    REG_COV_ON     = 3'd2,
    REG_COV_PCT    = 3'd3,
    REG_INTRON_ON  = 3'd4,
    REG_INTRON_MIN = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_KEPT     = 2'd0,
    VERDICT_UNMAPPED = 2'd1,
    VERDICT_IDENTITY = 2'd2,
    VERDICT_COVERAGE = 2'd3
  } verdict_t;

  typedef struct packed {
    logic             id_on;
    logic [PCT_W-1:0] id_pct;
    logic             cov_on;
    logic [PCT_W-1:0] cov_pct;
    logic             intron_on;
    logic [LEN_W-1:0] intron_min;
  } cfg_t;

  // per-read tags, sampled with the last op
  typedef struct packed {
    logic       unmapped;
    logic [7:0] edit;
    logic       x0_present;
    logic [7:0] x0_value;
    logic       as_present;
    logic [7:0] as_value;
    logic       xs_present;
    logic [7:0] xs_value;
  } tag_t;

  typedef struct packed {
    logic [31:0] read_length;
    logic [31:0] alignment_length;
    logic [31:0] hard_clip_count;
    logic [31:0] soft_clip_count;
    logic [31:0] delete_count;
    logic [31:0] insert_count;
    logic [7:0]  mismatch_count;
    logic [32:0] match_count;
    logic        is_unique;
    verdict_t    verdict;
    logic        keep;
  } result_t;

endpackage

### src/caqf_front.sv
// Front end: decodes CIGAR ops, accumulates saturating sums, emits one record per read.
module caqf_front #(
  parameter int COUNT_BITS = caqf_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  caqf_pkg::cfg_t               cfg,
  input  logic                         accept,
  input  logic [3:0]                   op_code,
  input  logic [caqf_pkg::LEN_W-1:0]   op_length,
  input  logic                         last_op,
  input  caqf_pkg::tag_t               tag,
  output logic                         push,
  output logic [5*COUNT_BITS+$bits(caqf_pkg::tag_t)-1:0] record
);

  localparam int AW = ((COUNT_BITS > caqf_pkg::LEN_W) ? COUNT_BITS : caqf_pkg::LEN_W) + 1;
  localparam logic [AW-1:0] SUM_MAX = AW'({COUNT_BITS{1'b1}});

  logic [COUNT_BITS-1:0] sums [caqf_pkg::KIND_COUNT];
  logic [COUNT_BITS-1:0] upd  [caqf_pkg::KIND_COUNT];
  caqf_pkg::kind_t       kind;
  logic                  counted;
  logic [AW-1:0]         add_raw;
  logic [COUNT_BITS-1:0] add_sat;

  always_comb begin
    kind    = caqf_pkg::KIND_M;
    counted = 1'b1;
    unique case (op_code)
      caqf_pkg::OP_MATCH:  kind = caqf_pkg::KIND_M;
      caqf_pkg::OP_INSERT: kind = caqf_pkg::KIND_I;
      caqf_pkg::OP_DELETE: begin
        kind    = caqf_pkg::KIND_D;
        counted = !cfg.intron_on || (op_length < cfg.intron_min);
      end
      caqf_pkg::OP_SOFT:   kind = caqf_pkg::KIND_S;
      caqf_pkg::OP_HARD:   kind = caqf_pkg::KIND_H;
      default:             counted = 1'b0;
    endcase
    if (tag.unmapped) counted = 1'b0;
  end

  assign add_raw = AW'(sums[kind]) + AW'(op_length);
  assign add_sat = (add_raw > SUM_MAX) ? {COUNT_BITS{1'b1}} : add_raw[COUNT_BITS-1:0];

  always_comb begin
    for (int k = 0; k < caqf_pkg::KIND_COUNT; k++) begin
      upd[k] = (counted && kind == caqf_pkg::kind_t'(k)) ? add_sat : sums[k];
    end
  end

  assign push   = accept && last_op;
  assign record = {tag, upd[caqf_pkg::KIND_H], upd[caqf_pkg::KIND_S], upd[caqf_pkg::KIND_D],
                   upd[caqf_pkg::KIND_I], upd[caqf_pkg::KIND_M]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < caqf_pkg::KIND_COUNT; k++) sums[k] <= '0;
    end else if (accept) begin
      for (int k = 0; k < caqf_pkg::KIND_COUNT; k++) sums[k] <= last_op ? '0 : upd[k];
    end
  end

endmodule

### src/caqf_queue.sv
// Short FIFO between the front end and the verdict pipeline.
module caqf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = caqf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("queue read while empty");
  a_ptrs_empty: assert property (@(posedge clk) disable iff (rst)
      (empty || full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

### src/caqf_back.sv
// Back end: derived lengths, percent tests by cross-multiplication, verdict register.
module caqf_back #(
  parameter int COUNT_BITS = caqf_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  caqf_pkg::cfg_t      cfg,
  input  logic                rec_avail,
  input  logic [5*COUNT_BITS+$bits(caqf_pkg::tag_t)-1:0] record,
  output logic                rec_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output caqf_pkg::result_t   result
);

  localparam int CB    = COUNT_BITS;
  localparam int TAG_W = $bits(caqf_pkg::tag_t);
  localparam int REC_W = 5 * CB + TAG_W;
  localparam int PW    = caqf_pkg::PCT_W;
  localparam logic [CB+1:0] SUM_MAX = (CB+2)'({CB{1'b1}});
  localparam logic signed [CB+PW+1:0] SCALE_S = (CB+PW+2)'(caqf_pkg::PERCENT_SCALE);
  localparam logic [CB+PW-1:0]        SCALE_U = (CB+PW)'(caqf_pkg::PERCENT_SCALE);

  logic adv;
  assign adv     = !out_valid || out_ready;
  assign rec_pop = rec_avail && adv;

  // stage 1: raw partial sums
  logic                 s1_valid;
  caqf_pkg::tag_t       s1_tag;
  logic [CB-1:0]        s1_ins, s1_del, s1_sc, s1_hc;
  logic [CB:0]          s1_frag_raw, s1_clip_raw;
  logic signed [CB:0]   s1_match;

  // stage 2: saturated lengths
  logic                 s2_valid;
  caqf_pkg::tag_t       s2_tag;
  logic [CB-1:0]        s2_ins, s2_del, s2_sc, s2_hc;
  logic [CB-1:0]        s2_frag, s2_align, s2_read;
  logic signed [CB:0]   s2_match;
  logic [CB+1:0]        align_raw, read_raw;

  // stage 3: products
  logic                       s3_valid;
  caqf_pkg::tag_t             s3_tag;
  logic [CB-1:0]              s3_ins, s3_del, s3_sc, s3_hc, s3_align, s3_read;
  logic signed [CB:0]         s3_match;
  logic                       s3_align_zero, s3_read_zero;
  logic signed [CB+PW+1:0]    s3_id_lhs;
  logic [CB+PW-1:0]           s3_id_rhs, s3_cov_lhs, s3_cov_rhs;

  caqf_pkg::result_t res_next;
  logic              id_low, cov_low, uniq;

  assign align_raw = (CB+2)'(s1_frag_raw) + (CB+2)'(s1_del);
  assign read_raw  = (CB+2)'(s1_frag_raw) + (CB+2)'(s1_clip_raw);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tag      <= caqf_pkg::tag_t'(record[REC_W-1 -: TAG_W]);
      s1_ins      <= record[2*CB-1:CB];
      s1_del      <= record[3*CB-1:2*CB];
      s1_sc       <= record[4*CB-1:3*CB];
      s1_hc       <= record[5*CB-1:4*CB];
      s1_frag_raw <= (CB+1)'(record[CB-1:0]) + (CB+1)'(record[2*CB-1:CB]);
      s1_clip_raw <= (CB+1)'(record[4*CB-1:3*CB]) + (CB+1)'(record[5*CB-1:4*CB]);
      s1_match    <= $signed((CB+1)'(record[CB-1:0]))
                     - $signed((CB+1)'(record[REC_W-2 -: 8]));

      s2_tag   <= s1_tag;
      s2_ins   <= s1_ins;
      s2_del   <= s1_del;
      s2_sc    <= s1_sc;
      s2_hc    <= s1_hc;
      s2_match <= s1_match;
      s2_frag  <= (s1_frag_raw > (CB+1)'({CB{1'b1}})) ? {CB{1'b1}} : s1_frag_raw[CB-1:0];
      s2_align <= (align_raw > SUM_MAX) ? {CB{1'b1}} : align_raw[CB-1:0];
      s2_read  <= (read_raw > SUM_MAX) ? {CB{1'b1}} : read_raw[CB-1:0];

      s3_tag        <= s2_tag;
      s3_ins        <= s2_ins;
      s3_del        <= s2_del;
      s3_sc         <= s2_sc;
      s3_hc         <= s2_hc;
      s3_align      <= s2_align;
      s3_read       <= s2_read;
      s3_match      <= s2_match;
      s3_align_zero <= (s2_align == '0);
      s3_read_zero  <= (s2_read == '0);
      s3_id_lhs     <= (CB+PW+2)'(s2_match) * SCALE_S;
      s3_id_rhs     <= (CB+PW)'(cfg.id_pct) * (CB+PW)'(s2_align);
      s3_cov_lhs    <= (CB+PW)'(s2_frag) * SCALE_U;
      s3_cov_rhs    <= (CB+PW)'(cfg.cov_pct) * (CB+PW)'(s2_read);

      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= rec_pop;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_comb begin
    // zero alignment length: +inf passes, NaN passes, -inf drops
    id_low  = s3_align_zero ? (s3_match < 0)
                            : (s3_id_lhs <= $signed((CB+PW+2)'(s3_id_rhs)));
    cov_low = !s3_read_zero && (s3_cov_lhs <= s3_cov_rhs);
    uniq    = (s3_tag.x0_present && s3_tag.x0_value == 8'd1) ||
              (s3_tag.as_present && s3_tag.xs_present && s3_tag.as_value != s3_tag.xs_value);

    res_next = '0;
    if (s3_tag.unmapped) begin
      res_next.verdict = caqf_pkg::VERDICT_UNMAPPED;
    end else begin
      if (cfg.id_on && id_low)        res_next.verdict = caqf_pkg::VERDICT_IDENTITY;
      else if (cfg.cov_on && cov_low) res_next.verdict = caqf_pkg::VERDICT_COVERAGE;
      else                            res_next.verdict = caqf_pkg::VERDICT_KEPT;
      res_next.keep             = (res_next.verdict == caqf_pkg::VERDICT_KEPT);
      res_next.is_unique        = res_next.keep && uniq;
      res_next.match_count      = 33'(s3_match);
      res_next.mismatch_count   = s3_tag.edit;
      res_next.insert_count     = 32'(s3_ins);
      res_next.delete_count     = 32'(s3_del);
      res_next.soft_clip_count  = 32'(s3_sc);
      res_next.hard_clip_count  = 32'(s3_hc);
      res_next.alignment_length = 32'(s3_align);
      res_next.read_length      = 32'(s3_read);
    end
  end

endmodule

### src/cigar_alignment_quality_filter_unit.sv
// A read's result passes the record queue, stages 1-3 and the result register.
// Throughput: one op request per cycle; one result per cycle while the output is taken.
// The front accumulates ops; a 4-entry record queue feeds a 4-stage verdict pipeline.
// The input stalls only when the record queue is full.
// Reset (rst, synchronous) clears config, sums, queue and all valid bits.
module cigar_alignment_quality_filter_unit #(
  parameter int COUNT_BITS = caqf_pkg::COUNT_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [27:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op_code[3:0] op_length[31:4] edit_distance[39:32] best_hits_present[40]
  // best_hits_value[48:41] score_present[49] score_value[57:50]
  // second_score_present[58] second_score_value[66:59] zero[71:67]
  input  logic [71:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  // unmapped[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // keep[0] verdict[2:1] is_unique[3] match_count[36:4] mismatch_count[44:37]
  // insert_count[76:45] delete_count[108:77] soft_clip_count[140:109]
  // hard_clip_count[172:141] alignment_length[204:173] read_length[236:205] zero[239:237]
  output logic [239:0] m_axis_tdata
);

  localparam int REC_W = 5 * COUNT_BITS + $bits(caqf_pkg::tag_t);

  caqf_pkg::cfg_t    cfg;
  caqf_pkg::tag_t    tag;
  caqf_pkg::result_t result;
  logic              accept, push, pop, full, empty;
  logic [REC_W-1:0]  rec_in, rec_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        caqf_pkg::REG_ID_ON:      cfg.id_on      <= cfg_data[0];
        caqf_pkg::REG_ID_PCT:     cfg.id_pct     <= cfg_data[caqf_pkg::PCT_W-1:0];
        caqf_pkg::REG_COV_ON:     cfg.cov_on     <= cfg_data[0];
        caqf_pkg::REG_COV_PCT:    cfg.cov_pct    <= cfg_data[caqf_pkg::PCT_W-1:0];
        caqf_pkg::REG_INTRON_ON:  cfg.intron_on  <= cfg_data[0];
        caqf_pkg::REG_INTRON_MIN: cfg.intron_min <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tag.unmapped   = s_axis_tuser;
  assign tag.edit       = s_axis_tdata[39:32];
  assign tag.x0_present = s_axis_tdata[40];
  assign tag.x0_value   = s_axis_tdata[48:41];
  assign tag.as_present = s_axis_tdata[49];
  assign tag.as_value   = s_axis_tdata[57:50];
  assign tag.xs_present = s_axis_tdata[58];
  assign tag.xs_value   = s_axis_tdata[66:59];

  caqf_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .op_code   (s_axis_tdata[3:0]),
    .op_length (s_axis_tdata[31:4]),
    .last_op   (s_axis_tlast),
    .tag       (tag),
    .push      (push),
    .record    (rec_in)
  );

  caqf_queue #(.WIDTH(REC_W), .DEPTH(caqf_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (rec_in),
    .pop       (pop),
    .pop_data  (rec_out),
    .full      (full),
    .empty     (empty)
  );

  caqf_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .rec_avail (!empty),
    .record    (rec_out),
    .rec_pop   (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result)
  );

  assign m_axis_tdata = {3'b000, result};

endmodule

### sim/tb_top.sv
// Self-checking testbench: streams CIGAR op requests and checks each read's verdict and counts.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [3:0]  OP_REF_SKIP = 4'd3;
  localparam logic [3:0]  OP_BOGUS    = 4'd15;
  localparam logic [27:0] LEN_MAX     = 28'hFFFFFFF;
  localparam logic [63:0] TALLY_CAP   = 64'hFFFF_FFFF;
  localparam int          HOLD_CYCLES = 200;
  localparam int          PHASE_OPS   = 100;

  typedef struct packed {
    logic [3:0]       code;
    logic [27:0]      len;
    logic             last;
    caqf_pkg::tag_t   tags;
  } cigar_op_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [27:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [239:0] m_axis_tdata;

  cigar_alignment_quality_filter_unit uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  cigar_op_t           op_backlog[$];
  caqf_pkg::result_t   pending_verdicts[$];
  cigar_op_t           op_on_bus;
  caqf_pkg::result_t   predicted, mon_got, mon_want;

  caqf_pkg::cfg_t mdl_cfg = '0;
  logic [63:0] m_tally = '0, i_tally = '0, d_tally = '0, s_tally = '0, h_tally = '0;

  int ops_queued = 0, ops_accepted = 0, reads_checked = 0, mismatches = 0;
  int sat_reads = 0;
  int verdict_count[4] = '{0, 0, 0, 0};
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_go = 1'b0, hold_done = 1'b0;
  int hold_cnt = 0;

  function automatic logic [63:0] capped_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > TALLY_CAP) ? TALLY_CAP : s;
  endfunction

  function automatic void zero_tallies();
    m_tally = '0;
    i_tally = '0;
    d_tally = '0;
    s_tally = '0;
    h_tally = '0;
  endfunction

  // accumulate one op; on the read's last op build its verdict and counts
  function automatic bit filter_op(input cigar_op_t op, output caqf_pkg::result_t res);
    longint              match;
    logic [63:0]         aln, frag, rlen;
    bit                  id_low, cov_low, uniq;
    caqf_pkg::verdict_t  v;
    res = '0;
    if (!op.tags.unmapped) begin
      case (op.code)
        caqf_pkg::OP_MATCH:  m_tally = capped_sum(m_tally, 64'(op.len));
        caqf_pkg::OP_INSERT: i_tally = capped_sum(i_tally, 64'(op.len));
        caqf_pkg::OP_DELETE: begin
          if (!mdl_cfg.intron_on || op.len < mdl_cfg.intron_min)
            d_tally = capped_sum(d_tally, 64'(op.len));
        end
        caqf_pkg::OP_SOFT:   s_tally = capped_sum(s_tally, 64'(op.len));
        caqf_pkg::OP_HARD:   h_tally = capped_sum(h_tally, 64'(op.len));
        default: ;
      endcase
    end
    if (!op.last) return 1'b0;
    if (op.tags.unmapped) begin
      res.verdict = caqf_pkg::VERDICT_UNMAPPED;
      zero_tallies();
      return 1'b1;
    end
    match = longint'(m_tally) - longint'(op.tags.edit);
    frag  = capped_sum(m_tally, i_tally);
    aln   = capped_sum(frag, d_tally);
    rlen  = capped_sum(capped_sum(frag, s_tally), h_tally);
    // empty alignment: identity is -inf if mismatches remain, else NaN (passes)
    if (aln == 0) id_low = (match < 0);
    else id_low = (match * 100) <= (longint'(mdl_cfg.id_pct) * longint'(aln));
    cov_low = (rlen == 0) ? 1'b0 : ((frag * 64'd100) <= (64'(mdl_cfg.cov_pct) * rlen));
    v = caqf_pkg::VERDICT_KEPT;
    if (mdl_cfg.id_on && id_low) v = caqf_pkg::VERDICT_IDENTITY;
    else if (mdl_cfg.cov_on && cov_low) v = caqf_pkg::VERDICT_COVERAGE;
    uniq = (op.tags.x0_present && op.tags.x0_value == 8'd1) ||
           (op.tags.as_present && op.tags.xs_present && op.tags.as_value != op.tags.xs_value);
    res.keep             = (v == caqf_pkg::VERDICT_KEPT);
    res.verdict          = v;
    res.is_unique        = (v == caqf_pkg::VERDICT_KEPT) && uniq;
    res.match_count      = 33'(match);
    res.mismatch_count   = op.tags.edit;
    res.insert_count     = i_tally[31:0];
    res.delete_count     = d_tally[31:0];
    res.soft_clip_count  = s_tally[31:0];
    res.hard_clip_count  = h_tally[31:0];
    res.alignment_length = aln[31:0];
    res.read_length      = rlen[31:0];
    zero_tallies();
    return 1'b1;
  endfunction

  function automatic caqf_pkg::tag_t mk_tags(bit unm, logic [7:0] edit, bit x0p,
                                             logic [7:0] x0v, bit asp, logic [7:0] asv,
                                             bit xsp, logic [7:0] xsv);
    return {unm, edit, x0p, x0v, asp, asv, xsp, xsv};
  endfunction

  function automatic caqf_pkg::tag_t random_tags();
    caqf_pkg::tag_t t;
    t = 36'({$urandom, $urandom});
    if ($urandom_range(9) < 7) t.edit = 8'($urandom_range(40));
    if ($urandom_range(1) == 1) t.x0_value = 8'd1;
    if ($urandom_range(9) < 3) t.xs_value = t.as_value;
    return t;
  endfunction

  function automatic logic [3:0] valid_code();
    case ($urandom_range(5))
      0, 1:    return caqf_pkg::OP_MATCH;
      2:       return caqf_pkg::OP_INSERT;
      3:       return caqf_pkg::OP_DELETE;
      4:       return caqf_pkg::OP_SOFT;
      default: return caqf_pkg::OP_HARD;
    endcase
  endfunction

  function automatic logic [27:0] random_len(logic [3:0] code);
    int unsigned p;
    p = $urandom_range(9);
    if (p < 2) return 28'($urandom);
    if (code == caqf_pkg::OP_DELETE && mdl_cfg.intron_on && p < 5)
      return mdl_cfg.intron_min + 28'($urandom_range(2)) - 28'd1;
    if (code == caqf_pkg::OP_MATCH) return 28'($urandom_range(400, 40));
    return 28'($urandom_range(60));
  endfunction

  task automatic add_op(logic [3:0] code, logic [27:0] len, bit last, caqf_pkg::tag_t tags);
    cigar_op_t op;
    op.code = code;
    op.len  = len;
    op.last = last;
    op.tags = tags;
    op_backlog.push_back(op);
    ops_queued++;
  endtask

  task automatic queue_random_read();
    int unsigned     pick;
    int              n, k;
    bit              sat, unm_read;
    logic [3:0]      sat_code, code;
    caqf_pkg::tag_t  t;
    pick     = $urandom_range(99);
    sat      = pick < 6;
    unm_read = (pick >= 6) && (pick < 16);
    n        = sat ? int'($urandom_range(20, 17)) : int'($urandom_range(6, 1));
    sat_code = valid_code();
    for (k = 0; k < n; k++) begin
      t = random_tags();
      if (sat) begin
        code = ($urandom_range(1) == 1) ? sat_code : valid_code();
        t.unmapped = 1'b0;
        add_op(code, LEN_MAX - 28'($urandom_range(3)), k == n - 1, t);
      end else begin
        code = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : valid_code();
        t.unmapped = (k == n - 1) ? unm_read : ($urandom_range(32) == 0);
        add_op(code, random_len(code), k == n - 1, t);
      end
    end
  endtask

  task automatic write_reg(caqf_pkg::cfg_reg_t idx, logic [27:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      caqf_pkg::REG_ID_ON:      mdl_cfg.id_on      = val[0];
      caqf_pkg::REG_ID_PCT:     mdl_cfg.id_pct     = val[6:0];
      caqf_pkg::REG_COV_ON:     mdl_cfg.cov_on     = val[0];
      caqf_pkg::REG_COV_PCT:    mdl_cfg.cov_pct    = val[6:0];
      caqf_pkg::REG_INTRON_ON:  mdl_cfg.intron_on  = val[0];
      caqf_pkg::REG_INTRON_MIN: mdl_cfg.intron_min = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(caqf_pkg::cfg_t c);
    write_reg(caqf_pkg::REG_ID_ON, 28'(c.id_on));
    write_reg(caqf_pkg::REG_ID_PCT, 28'(c.id_pct));
    write_reg(caqf_pkg::REG_COV_ON, 28'(c.cov_on));
    write_reg(caqf_pkg::REG_COV_PCT, 28'(c.cov_pct));
    write_reg(caqf_pkg::REG_INTRON_ON, 28'(c.intron_on));
    write_reg(caqf_pkg::REG_INTRON_MIN, c.intron_min);
  endtask

  // every request accepted and every verdict back, then pipeline latency
  task automatic drain();
    while (ops_accepted != ops_queued || pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on read %0d, %s: expected %0h, got %0h", reads_checked, name, want, got);
    end
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (filter_op(op_on_bus, predicted)) pending_verdicts.push_back(predicted);
        ops_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          op_on_bus = op_backlog.pop_front();
          s_axis_tdata  <= {5'b0, op_on_bus.tags.xs_value, op_on_bus.tags.xs_present,
                            op_on_bus.tags.as_value, op_on_bus.tags.as_present,
                            op_on_bus.tags.x0_value, op_on_bus.tags.x0_present,
                            op_on_bus.tags.edit, op_on_bus.len, op_on_bus.code};
          s_axis_tlast  <= op_on_bus.last;
          s_axis_tuser  <= op_on_bus.tags.unmapped;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mon_got = caqf_pkg::result_t'(m_axis_tdata[236:0]);
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: verdict %0d, read_length %0h",
                   mon_got.verdict, mon_got.read_length);
      end else begin
        mon_want = pending_verdicts.pop_front();
        check_field("keep", 64'(mon_want.keep), 64'(mon_got.keep));
        check_field("verdict", 64'(mon_want.verdict), 64'(mon_got.verdict));
        check_field("is_unique", 64'(mon_want.is_unique), 64'(mon_got.is_unique));
        check_field("match_count", 64'(mon_want.match_count), 64'(mon_got.match_count));
        check_field("mismatch_count", 64'(mon_want.mismatch_count),
                    64'(mon_got.mismatch_count));
        check_field("insert_count", 64'(mon_want.insert_count), 64'(mon_got.insert_count));
        check_field("delete_count", 64'(mon_want.delete_count), 64'(mon_got.delete_count));
        check_field("soft_clip_count", 64'(mon_want.soft_clip_count),
                    64'(mon_got.soft_clip_count));
        check_field("hard_clip_count", 64'(mon_want.hard_clip_count),
                    64'(mon_got.hard_clip_count));
        check_field("alignment_length", 64'(mon_want.alignment_length),
                    64'(mon_got.alignment_length));
        check_field("read_length", 64'(mon_want.read_length), 64'(mon_got.read_length));
        verdict_count[mon_want.verdict]++;
        if (mon_want.read_length == 32'hFFFF_FFFF) sat_reads++;
        reads_checked++;
      end
    end
  end

  initial begin
    caqf_pkg::cfg_t settings[5];
    int             p, k;
    caqf_pkg::tag_t no_tags;
    settings[0] = {1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 28'd0};
    settings[1] = {1'b1, 7'd100, 1'b1, 7'd127, 1'b1, 28'd0};
    settings[2] = {1'b1, 7'd85, 1'b1, 7'd60, 1'b1, 28'd150};
    settings[3] = {1'b0, 7'd127, 1'b1, 7'd90, 1'b1, LEN_MAX};
    settings[4] = {1'b1, 7'd50, 1'b0, 7'd30, 1'b0, 28'd200};
    no_tags = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed reads
    apply_setting({1'b1, 7'd80, 1'b1, 7'd50, 1'b1, 28'd1000});
    add_op(caqf_pkg::OP_MATCH, 28'd100, 1'b0, no_tags);
    add_op(caqf_pkg::OP_INSERT, 28'd5, 1'b0, no_tags);
    add_op(caqf_pkg::OP_DELETE, 28'd10, 1'b0, no_tags);
    add_op(caqf_pkg::OP_SOFT, 28'd3, 1'b0, no_tags);
    add_op(caqf_pkg::OP_HARD, 28'd2, 1'b1,
           mk_tags(1'b0, 8'd4, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0));
    // ignored codes, max length, deletion at and just under the intron length
    add_op(OP_REF_SKIP, 28'd50, 1'b0, no_tags);
    add_op(OP_BOGUS, LEN_MAX, 1'b0, no_tags);
    add_op(caqf_pkg::OP_MATCH, LEN_MAX, 1'b0, no_tags);
    add_op(caqf_pkg::OP_DELETE, 28'd1000, 1'b0, no_tags);
    add_op(caqf_pkg::OP_DELETE, 28'd999, 1'b1,
           mk_tags(1'b0, 8'd255, 1'b1, 8'd255, 1'b1, 8'd255, 1'b1, 8'd0));
    // empty alignment with and without mismatches
    add_op(caqf_pkg::OP_SOFT, 28'd7, 1'b1,
           mk_tags(1'b0, 8'd3, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0));
    add_op(caqf_pkg::OP_HARD, 28'd0, 1'b1, no_tags);
    // deletions only: zero read length
    add_op(caqf_pkg::OP_DELETE, 28'd20, 1'b1, no_tags);
    // unmapped read, and an unmapped op inside a mapped read
    add_op(caqf_pkg::OP_MATCH, 28'd50, 1'b0, no_tags);
    add_op(caqf_pkg::OP_INSERT, 28'd3, 1'b1,
           mk_tags(1'b1, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0));
    add_op(caqf_pkg::OP_MATCH, 28'd10, 1'b0,
           mk_tags(1'b1, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 8'd0));
    add_op(caqf_pkg::OP_MATCH, 28'd40, 1'b1,
           mk_tags(1'b0, 8'd0, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0, 8'd0));
    // low aligned fraction; kept but not unique
    add_op(caqf_pkg::OP_MATCH, 28'd10, 1'b0, no_tags);
    add_op(caqf_pkg::OP_SOFT, 28'd30, 1'b1, no_tags);
    add_op(caqf_pkg::OP_MATCH, 28'd20, 1'b1,
           mk_tags(1'b0, 8'd0, 1'b1, 8'd2, 1'b1, 8'd5, 1'b1, 8'd5));
    drain();

    // random phases, one handshake mix each
    for (p = 0; p < 4; p++) begin
      apply_setting(settings[p]);
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      k = ops_queued;
      while (ops_queued - k < PHASE_OPS) queue_random_read();
      drain();
    end

    // back-pressure: output held off while short reads keep coming
    apply_setting(settings[4]);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    hold_go <= 1'b1;
    for (k = 0; k < 30; k++) begin
      if ($urandom_range(1) == 1)
        add_op(caqf_pkg::OP_MATCH, 28'($urandom_range(100, 20)), 1'b0, random_tags());
      add_op(caqf_pkg::OP_SOFT, 28'($urandom_range(30)), 1'b1, random_tags());
    end
    while (!hold_done) @(posedge clk);
    drain();

    $display("Checked %0d reads from %0d op requests: six register settings, four handshake mixes and a %0d-cycle output hold.",
             reads_checked, ops_accepted, HOLD_CYCLES);
    $display("Verdicts: kept %0d, unmapped %0d, low identity %0d, low coverage %0d; saturated read lengths %0d.",
             verdict_count[caqf_pkg::VERDICT_KEPT], verdict_count[caqf_pkg::VERDICT_UNMAPPED],
             verdict_count[caqf_pkg::VERDICT_IDENTITY],
             verdict_count[caqf_pkg::VERDICT_COVERAGE], sat_reads);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### cigar_alignment_quality_filter_unit.f
src/caqf_pkg.sv
src/caqf_front.sv
src/caqf_queue.sv
src/caqf_back.sv
src/cigar_alignment_quality_filter_unit.sv
sim/tb_top.sv
